// ----- hw/rtl/tcpmq_pkg.sv -----
// Package for the three-class priority message queue: widths, codes and shared types.
`timescale 1ns / 1ps

package tcpmq_pkg;

    // Fixed field widths
    localparam int HANDLE_W    = 6;
    localparam int CMD_W       = 2;
    localparam int CLASS_W     = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int NCLASS      = 3;

    // Default number of handles
    localparam int DEF_HANDLES = 64;

    // Command codes on the input port
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_CLR = 2'd2
    } t_cmd;

    // Queue classes, highest priority first
    localparam logic [CLASS_W-1:0] CLS_HIGH = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SYS  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LOW  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic enq;         // append handle to its class queue
        logic deq_rd;      // pick class, read successor link
        logic deq_commit;  // update head and counts, report handle
        logic clr;         // empty every queue
        logic plain_done;  // non-dequeue transaction: report no handle
    } t_dp_cmd;

endpackage

// ----- hw/rtl/tcpmq_ctrl.sv -----
// Controller state machine for the priority message queue.
`timescale 1ns / 1ps

module tcpmq_ctrl
    import tcpmq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] i_command,
    output logic             busy,
    output logic             o_strobe,
    output t_dp_cmd          o_dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_DEQ
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;
    logic   accept;
    logic   is_deq;

    assign accept = start && !r_busy;
    assign is_deq = (i_command == CMD_DEQ);

    // Decode the accepted transaction into datapath commands
    always_comb begin
        o_dp_cmd            = '0;
        o_dp_cmd.enq        = accept && (i_command == CMD_ENQ);
        o_dp_cmd.deq_rd     = accept && is_deq;
        o_dp_cmd.clr        = accept && (i_command == CMD_CLR);
        o_dp_cmd.plain_done = accept && !is_deq;
        o_dp_cmd.deq_commit = (r_state == S_DEQ);
    end

    // State, busy and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && is_deq) begin
                        r_state  <= S_DEQ;
                        r_busy   <= 1'b1;
                        r_strobe <= 1'b0;
                    end else begin
                        r_busy   <= 1'b0;
                        r_strobe <= accept;
                    end
                end
                S_DEQ: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

    // A dequeue always leaves its commit state with a result strobe in the next cycle
    a_deq_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ) |=> (r_state == S_IDLE) && r_strobe)
        else $error("dequeue did not complete with a strobe");

    // No result is shown while a dequeue is still in flight
    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_strobe)
        else $error("strobe while busy");

endmodule

// ----- hw/rtl/tcpmq_dp.sv -----
// Datapath: link memory, per-class head/tail/count registers and result registers.
`timescale 1ns / 1ps

module tcpmq_dp
    import tcpmq_pkg::*;
#(
    parameter int HANDLES = DEF_HANDLES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [HANDLE_W-1:0]    i_msg_handle,
    input  logic                   i_high_priority,
    input  logic                   i_system_class,
    output logic [HANDLE_W-1:0]    o_out_handle,
    output logic                   o_out_valid,
    output logic [CLASS_W-1:0]     o_served_class,
    output logic [COUNT_OUT_W-1:0] o_total_count,
    output logic [COUNT_OUT_W-1:0] o_high_count,
    output logic [COUNT_OUT_W-1:0] o_system_count,
    output logic [COUNT_OUT_W-1:0] o_low_count
);

    localparam int AW = $clog2(HANDLES);
    localparam int CW = $clog2(HANDLES + 1);

    // Shared next-pointer memory, indexed by handle
    logic [HANDLE_W-1:0] r_link_mem [HANDLES];
    logic [HANDLE_W-1:0] r_rd_link;

    logic [HANDLE_W-1:0] r_head  [NCLASS];
    logic [HANDLE_W-1:0] r_tail  [NCLASS];
    logic [CW-1:0]       r_count [NCLASS];
    logic [CW-1:0]       r_total;

    // Dequeue context held between read and commit
    logic                r_deq_hit;
    logic [CLASS_W-1:0]  r_deq_cls;
    logic [HANDLE_W-1:0] r_deq_head;

    logic [HANDLE_W-1:0] r_out_handle;
    logic                r_out_valid;
    logic [CLASS_W-1:0]  r_out_cls;

    logic [CLASS_W-1:0]  enq_cls;
    logic                enq_ok;
    logic                enq_link;
    logic [CLASS_W-1:0]  deq_cls;
    logic                deq_hit;

    // Enqueue class and acceptance
    assign enq_cls  = i_high_priority ? CLS_HIGH : (i_system_class ? CLS_SYS : CLS_LOW);
    assign enq_ok   = i_cmd.enq && (32'(i_msg_handle) < HANDLES)
                      && (r_total < CW'(HANDLES));
    assign enq_link = enq_ok && (r_count[enq_cls] != '0);

    // Strict priority pick of the dequeue class
    always_comb begin
        deq_hit = 1'b1;
        priority if (r_count[CLS_HIGH] != '0) begin
            deq_cls = CLS_HIGH;
        end else if (r_count[CLS_SYS] != '0) begin
            deq_cls = CLS_SYS;
        end else if (r_count[CLS_LOW] != '0) begin
            deq_cls = CLS_LOW;
        end else begin
            deq_cls = CLS_HIGH;
            deq_hit = 1'b0;
        end
    end

    // Link memory: write on enqueue behind a tail, read on dequeue
    always_ff @(posedge i_clk) begin
        if (enq_link) begin
            r_link_mem[AW'(r_tail[enq_cls])] <= i_msg_handle;
        end
        if (i_cmd.deq_rd) begin
            r_rd_link <= r_link_mem[AW'(r_head[deq_cls])];
        end
    end

    // Queue control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCLASS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_total   <= '0;
            r_deq_hit <= 1'b0;
        end else begin
            if (i_cmd.deq_rd) begin
                r_deq_hit <= deq_hit;
            end
            priority if (i_cmd.clr) begin
                for (int i = 0; i < NCLASS; i++) begin
                    r_head[i]  <= '0;
                    r_tail[i]  <= '0;
                    r_count[i] <= '0;
                end
                r_total <= '0;
            end else if (enq_ok) begin
                if (r_count[enq_cls] == '0) begin
                    r_head[enq_cls] <= i_msg_handle;
                end
                r_tail[enq_cls]  <= i_msg_handle;
                r_count[enq_cls] <= r_count[enq_cls] + 1'b1;
                r_total          <= r_total + 1'b1;
            end else if (i_cmd.deq_commit && r_deq_hit) begin
                r_head[r_deq_cls]  <= r_rd_link;
                r_count[r_deq_cls] <= r_count[r_deq_cls] - 1'b1;
                r_total            <= r_total - 1'b1;
            end
        end
    end

    // Dequeue context and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.deq_rd) begin
            r_deq_cls  <= deq_cls;
            r_deq_head <= r_head[deq_cls];
        end
        if (i_cmd.deq_commit) begin
            r_out_handle <= r_deq_hit ? r_deq_head : '0;
            r_out_valid  <= r_deq_hit;
            r_out_cls    <= r_deq_hit ? r_deq_cls : CLS_HIGH;
        end else if (i_cmd.plain_done) begin
            r_out_handle <= '0;
            r_out_valid  <= 1'b0;
            r_out_cls    <= CLS_HIGH;
        end
    end

    assign o_out_handle   = r_out_handle;
    assign o_out_valid    = r_out_valid;
    assign o_served_class = r_out_cls;
    assign o_total_count  = COUNT_OUT_W'(r_total);
    assign o_high_count   = COUNT_OUT_W'(r_count[CLS_HIGH]);
    assign o_system_count = COUNT_OUT_W'(r_count[CLS_SYS]);
    assign o_low_count    = COUNT_OUT_W'(r_count[CLS_LOW]);

    // Total always equals the sum of the class counts
    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {2'b00, r_total} == ({2'b00, r_count[0]} + {2'b00, r_count[1]}
                             + {2'b00, r_count[2]}))
        else $error("total count out of step with class counts");

    // A committed dequeue removes exactly one handle
    a_deq_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.deq_commit && r_deq_hit) |=> (r_total == $past(r_total) - 1'b1))
        else $error("dequeue did not decrement total");

endmodule

// ----- hw/rtl/three_class_priority_message_queue.sv -----
// Enqueue, clear and unused commands report in the cycle after start is taken.
// A dequeue reads the link memory when start is taken, then commits in S_DEQ and reports.
// One enqueue or clear per cycle while busy is low; a dequeue holds busy high
// for the cycle between the link read and the head update, so no new start is taken then.
// Reset: synchronous, active low; all queues empty, link memory contents left as is.
// The receiver cannot stall: each result is valid only while o_strobe is high.
`timescale 1ns / 1ps

module three_class_priority_message_queue
    import tcpmq_pkg::*;
#(
    parameter int HANDLES = DEF_HANDLES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [CMD_W-1:0]       i_command,
    input  logic [HANDLE_W-1:0]    i_msg_handle,
    input  logic                   i_high_priority,
    input  logic                   i_system_class,
    output logic                   o_strobe,
    output logic [HANDLE_W-1:0]    o_out_handle,
    output logic                   o_out_valid,
    output logic [CLASS_W-1:0]     o_served_class,
    output logic [COUNT_OUT_W-1:0] o_total_count,
    output logic [COUNT_OUT_W-1:0] o_high_count,
    output logic [COUNT_OUT_W-1:0] o_system_count,
    output logic [COUNT_OUT_W-1:0] o_low_count
);

    t_dp_cmd dp_cmd;

    // Transaction sequencing
    tcpmq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .busy      (busy),
        .o_strobe  (o_strobe),
        .o_dp_cmd  (dp_cmd)
    );

    // Queue storage and result registers
    tcpmq_dp #(
        .HANDLES (HANDLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_msg_handle    (i_msg_handle),
        .i_high_priority (i_high_priority),
        .i_system_class  (i_system_class),
        .o_out_handle    (o_out_handle),
        .o_out_valid     (o_out_valid),
        .o_served_class  (o_served_class),
        .o_total_count   (o_total_count),
        .o_high_count    (o_high_count),
        .o_system_count  (o_system_count),
        .o_low_count     (o_low_count)
    );

endmodule

// ----- test/tb_three_class_priority_message_queue.sv -----
// Testbench for the three-class priority message queue: directed and random command traffic.
`timescale 1ns / 1ps

module tb_three_class_priority_message_queue;
    import tcpmq_pkg::*;

    localparam int                 NUM_HANDLES = DEF_HANDLES;
    localparam logic [CMD_W-1:0]   CMD_NOP     = 2'd3;  // unused code, changes nothing
    localparam int                 CYCLE_LIMIT = 200000;
    localparam int                 DRAIN_WAIT  = 4;

    // One reported result, field by field
    typedef struct {
        logic [HANDLE_W-1:0]    handle;
        logic                   valid;
        logic [CLASS_W-1:0]     served;
        logic [COUNT_OUT_W-1:0] total;
        logic [COUNT_OUT_W-1:0] high;
        logic [COUNT_OUT_W-1:0] sys;
        logic [COUNT_OUT_W-1:0] low;
    } t_queue_report;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       i_command;
    logic [HANDLE_W-1:0]    i_msg_handle;
    logic                   i_high_priority;
    logic                   i_system_class;
    logic                   o_strobe;
    logic [HANDLE_W-1:0]    o_out_handle;
    logic                   o_out_valid;
    logic [CLASS_W-1:0]     o_served_class;
    logic [COUNT_OUT_W-1:0] o_total_count;
    logic [COUNT_OUT_W-1:0] o_high_count;
    logic [COUNT_OUT_W-1:0] o_system_count;
    logic [COUNT_OUT_W-1:0] o_low_count;

    // Shadow copy of the queue state
    logic [HANDLE_W-1:0] link_mem [NUM_HANDLES];
    logic [HANDLE_W-1:0] head_of  [NCLASS];
    logic [HANDLE_W-1:0] tail_of  [NCLASS];
    int                  class_cnt[NCLASS];
    int                  total_cnt;
    bit                  queued   [NUM_HANDLES];  // stimulus hint only

    t_queue_report pending_reports[$];

    int error_count;
    int cycle_count;
    int idle_pct;
    int n_sent;
    int n_served;
    int n_empty_deq;
    int n_clears;
    int peak_total;

    three_class_priority_message_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_msg_handle    (i_msg_handle),
        .i_high_priority (i_high_priority),
        .i_system_class  (i_system_class),
        .o_strobe        (o_strobe),
        .o_out_handle    (o_out_handle),
        .o_out_valid     (o_out_valid),
        .o_served_class  (o_served_class),
        .o_total_count   (o_total_count),
        .o_high_count    (o_high_count),
        .o_system_count  (o_system_count),
        .o_low_count     (o_low_count)
    );

    // 20 ns clock, low phase first so the first rising edge comes after setup
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        error_count++;
        $display("MISMATCH at cycle %0d: %s expected %0d got %0d",
                 cycle_count, what, exp_val, got_val);
    endtask

    // Queue update for one accepted transaction; returns the expected report
    task automatic predict_queue_cmd(input logic [CMD_W-1:0] cmd,
                                     input logic [HANDLE_W-1:0] hnd,
                                     input logic hi, input logic sy,
                                     output t_queue_report rep);
        int cls;
        rep.handle = '0;
        rep.valid  = 1'b0;
        rep.served = CLS_HIGH;
        case (cmd)
            CMD_ENQ: begin
                cls = hi ? int'(CLS_HIGH) : (sy ? int'(CLS_SYS) : int'(CLS_LOW));
                if (total_cnt < NUM_HANDLES) begin
                    if (class_cnt[cls] == 0)
                        head_of[cls] = hnd;
                    else
                        link_mem[tail_of[cls]] = hnd;
                    tail_of[cls] = hnd;
                    class_cnt[cls]++;
                    total_cnt++;
                    queued[hnd] = 1'b1;
                end
            end
            CMD_DEQ: begin
                cls = 0;
                while (cls < NCLASS && class_cnt[cls] == 0)
                    cls++;
                if (cls < NCLASS) begin
                    rep.handle = head_of[cls];
                    rep.valid  = 1'b1;
                    rep.served = CLASS_W'(cls);
                    queued[head_of[cls]] = 1'b0;
                    head_of[cls] = link_mem[head_of[cls]];
                    class_cnt[cls]--;
                    total_cnt--;
                    n_served++;
                end else begin
                    n_empty_deq++;
                end
            end
            CMD_CLR: begin
                for (int c = 0; c < NCLASS; c++) begin
                    head_of[c]   = '0;
                    tail_of[c]   = '0;
                    class_cnt[c] = 0;
                end
                total_cnt = 0;
                foreach (queued[h])
                    queued[h] = 1'b0;
                n_clears++;
            end
            default: ;
        endcase
        rep.total = COUNT_OUT_W'(total_cnt);
        rep.high  = COUNT_OUT_W'(class_cnt[CLS_HIGH]);
        rep.sys   = COUNT_OUT_W'(class_cnt[CLS_SYS]);
        rep.low   = COUNT_OUT_W'(class_cnt[CLS_LOW]);
        if (total_cnt > peak_total)
            peak_total = total_cnt;
    endtask

    // Send one transaction; start stays high afterwards until the next call or a drain
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] hnd,
                            input logic hi, input logic sy);
        t_queue_report rep;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_msg_handle    <= hnd;
        i_high_priority <= hi;
        i_system_class  <= sy;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_queue_cmd(cmd, hnd, hi, sy, rep);
        pending_reports.push_back(rep);
        n_sent++;
    endtask

    // Stop sending and let every outstanding result arrive
    task automatic drain_results();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Prefer a handle that is not queued; the rest may be duplicates
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int base;
        base = $urandom_range(NUM_HANDLES - 1);
        if ($urandom_range(99) < 90) begin
            for (int k = 0; k < NUM_HANDLES; k++) begin
                if (!queued[(base + k) % NUM_HANDLES])
                    return HANDLE_W'((base + k) % NUM_HANDLES);
            end
        end
        return HANDLE_W'(base);
    endfunction

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_queue_report exp_rep;
        if (i_rst_n && o_strobe) begin
            if (pending_reports.size() == 0) begin
                error_count++;
                $display("MISMATCH at cycle %0d: unexpected result, handle %0d",
                         cycle_count, o_out_handle);
            end else begin
                exp_rep = pending_reports.pop_front();
                if (o_out_handle !== exp_rep.handle)
                    report_mismatch("out_handle", exp_rep.handle, o_out_handle);
                if (o_out_valid !== exp_rep.valid)
                    report_mismatch("out_valid", exp_rep.valid, o_out_valid);
                if (o_served_class !== exp_rep.served)
                    report_mismatch("served_class", exp_rep.served, o_served_class);
                if (o_total_count !== exp_rep.total)
                    report_mismatch("total_count", exp_rep.total, o_total_count);
                if (o_high_count !== exp_rep.high)
                    report_mismatch("high_count", exp_rep.high, o_high_count);
                if (o_system_count !== exp_rep.sys)
                    report_mismatch("system_count", exp_rep.sys, o_system_count);
                if (o_low_count !== exp_rep.low)
                    report_mismatch("low_count", exp_rep.low, o_low_count);
            end
        end
    end

    // Fill to capacity, push past full, then chain the last handle so every link is written
    task automatic test_fill_and_full();
        for (int h = 0; h < NUM_HANDLES; h++)
            send_cmd(CMD_ENQ, HANDLE_W'(h), 1'b1, 1'($urandom_range(1)));
        send_cmd(CMD_ENQ, '1, 1'b0, 1'b1);
        send_cmd(CMD_DEQ, '0, 1'b0, 1'b0);
        send_cmd(CMD_CLR, '1, 1'b1, 1'b1);
        send_cmd(CMD_ENQ, HANDLE_W'(NUM_HANDLES - 1), 1'b0, 1'b0);
        send_cmd(CMD_ENQ, '0, 1'b0, 1'b0);
        send_cmd(CMD_DEQ, '1, 1'b1, 1'b1);
        send_cmd(CMD_DEQ, '0, 1'b0, 1'b0);
        drain_results();
    endtask

    // Strict priority: high over system over low, FIFO inside a class
    task automatic test_priority_order();
        send_cmd(CMD_ENQ, 6'd5,  1'b0, 1'b0);
        send_cmd(CMD_ENQ, 6'd9,  1'b0, 1'b1);
        send_cmd(CMD_ENQ, 6'd12, 1'b0, 1'b0);
        send_cmd(CMD_ENQ, 6'd7,  1'b1, 1'b1);
        send_cmd(CMD_ENQ, 6'd42, 1'b0, 1'b1);
        send_cmd(CMD_ENQ, 6'd33, 1'b1, 1'b0);
        repeat (7)
            send_cmd(CMD_DEQ, HANDLE_W'($urandom), 1'($urandom), 1'($urandom));
        drain_results();
    endtask

    // Unused command, clear of filled queues, and reuse after the clear
    task automatic test_clear_and_unused();
        send_cmd(CMD_ENQ, 6'd21, 1'b1, 1'b0);
        send_cmd(CMD_ENQ, 6'd22, 1'b0, 1'b1);
        send_cmd(CMD_ENQ, 6'd23, 1'b0, 1'b0);
        send_cmd(CMD_NOP, '1, 1'b1, 1'b1);
        send_cmd(CMD_CLR, '0, 1'b0, 1'b0);
        send_cmd(CMD_DEQ, '1, 1'b1, 1'b1);
        send_cmd(CMD_ENQ, 6'd22, 1'b0, 1'b1);
        send_cmd(CMD_NOP, '0, 1'b0, 1'b0);
        send_cmd(CMD_DEQ, '0, 1'b0, 1'b0);
        drain_results();
    endtask

    // Random bursts with a varying enqueue share, so occupancy swings from empty to full
    task automatic test_random_traffic(input int sender_idle, input int n_items);
        int enq_share;
        int roll;
        idle_pct = sender_idle;
        enq_share = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                enq_share = $urandom_range(85, 15);
            roll = $urandom_range(99);
            if (roll < 2)
                send_cmd(CMD_CLR, HANDLE_W'($urandom), 1'($urandom), 1'($urandom));
            else if (roll < 4)
                send_cmd(CMD_NOP, HANDLE_W'($urandom), 1'($urandom), 1'($urandom));
            else if ($urandom_range(99) < enq_share)
                send_cmd(CMD_ENQ, pick_handle(), 1'($urandom), 1'($urandom));
            else
                send_cmd(CMD_DEQ, HANDLE_W'($urandom), 1'($urandom), 1'($urandom));
        end
        drain_results();
    endtask

    initial begin
        start           <= 1'b0;
        i_command       <= CMD_ENQ;
        i_msg_handle    <= '0;
        i_high_priority <= 1'b0;
        i_system_class  <= 1'b0;
        i_rst_n         <= 1'b0;
        cycle_count = 0;
        error_count = 0;
        idle_pct    = 0;
        n_sent      = 0;
        n_served    = 0;
        n_empty_deq = 0;
        n_clears    = 0;
        peak_total  = 0;
        total_cnt   = 0;
        for (int c = 0; c < NCLASS; c++) begin
            head_of[c]   = '0;
            tail_of[c]   = '0;
            class_cnt[c] = 0;
        end
        foreach (link_mem[h]) begin
            link_mem[h] = '0;
            queued[h]   = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_full();
        test_priority_order();
        test_clear_and_unused();
        test_random_traffic(17, 500);
        test_random_traffic(68, 500);
        test_random_traffic(0, 500);

        $display("Covered %0d transactions: %0d handles served, %0d dequeues on empty,",
                 n_sent, n_served, n_empty_deq);
        $display("%0d clears, peak occupancy %0d of %0d; %0d mismatches",
                 n_clears, peak_total, NUM_HANDLES, error_count);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
